>>> rtl/maze_floodfill_step_assert.svh
// assertion helpers used by maze_floodfill_step
`ifndef MAZE_FLOODFILL_STEP_ASSERT_SVH
`define MAZE_FLOODFILL_STEP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");

// next-cycle implication, checked out of reset
`define MFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

`endif

>>> rtl/mfs_pkg.sv
`timescale 1ns / 1ps

package mfs_pkg;

  localparam int unsigned GRID_SIDE   = 16;
  localparam int unsigned QUEUE_DEPTH = 256;

  localparam int unsigned CW    = $clog2(GRID_SIDE);
  localparam int unsigned CAW   = 2 * CW;
  localparam int unsigned NMEM  = 1 << CAW;
  localparam int unsigned QAW   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned DW    = 8;
  localparam int unsigned WW    = 4;
  localparam int unsigned SEED_LO = GRID_SIDE / 2 - 1;
  localparam int unsigned SEED_HI = GRID_SIDE / 2;

  localparam logic [DW-1:0] FAR_DIST = 8'd255;

  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_E = 2'd1;
  localparam logic [1:0] DIR_S = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;

  typedef enum logic [2:0] {
    ACT_FWD       = 3'd0,
    ACT_RIGHT     = 3'd1,
    ACT_RIGHT_CAL = 3'd2,
    ACT_LEFT      = 3'd3,
    ACT_LEFT_CAL  = 3'd4,
    ACT_UTURN     = 3'd5
  } action_e;

  typedef enum logic [3:0] {
    ST_WINIT,
    ST_IDLE,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_CLEAR,
    ST_SEED,
    ST_POP,
    ST_QDAT,
    ST_CELL,
    ST_NB_RD,
    ST_NB_UPD,
    ST_DEC_RD,
    ST_DEC_CAP,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [3:0] wall_sensors;
    logic       return_home;
  } in_t;

  typedef struct packed {
    logic [2:0] action;
    logic [3:0] new_x;
    logic [3:0] new_y;
    logic [1:0] new_heading;
    logic [7:0] cell_distance;
  } out_t;

  typedef struct packed {
    logic flush;
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic          ok;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
  } nb_t;

  function automatic logic [CAW-1:0] cell_addr(logic [CW-1:0] x, logic [CW-1:0] y);
    return {x, y};
  endfunction

  function automatic logic [WW-1:0] dir_bit(logic [1:0] d);
    return WW'(1) << d;
  endfunction

  // neighbor in an absolute direction, ok low when it falls off the grid
  function automatic nb_t neighbor(logic [CW-1:0] x, logic [CW-1:0] y, logic [1:0] d);
    nb_t r;
    r.ok = 1'b1;
    r.x  = x;
    r.y  = y;
    case (d)
      DIR_N: begin
        if ({1'b0, y} + (CW+1)'(1) >= (CW+1)'(GRID_SIDE)) r.ok = 1'b0;
        else r.y = y + CW'(1);
      end
      DIR_E: begin
        if ({1'b0, x} + (CW+1)'(1) >= (CW+1)'(GRID_SIDE)) r.ok = 1'b0;
        else r.x = x + CW'(1);
      end
      DIR_S: begin
        if (y == '0) r.ok = 1'b0;
        else r.y = y - CW'(1);
      end
      default: begin
        if (x == '0) r.ok = 1'b0;
        else r.x = x - CW'(1);
      end
    endcase
    return r;
  endfunction

  function automatic logic [WW-1:0] wall_reset(logic [CAW-1:0] a);
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [WW-1:0] w;
    x = a[CAW-1:CW];
    y = a[CW-1:0];
    w = '0;
    if (y == CW'(GRID_SIDE - 1)) w = w | dir_bit(DIR_N);
    if (x == CW'(GRID_SIDE - 1)) w = w | dir_bit(DIR_E);
    if (y == '0) w = w | dir_bit(DIR_S);
    if (x == '0) w = w | dir_bit(DIR_W);
    return w;
  endfunction

  function automatic logic [CAW-1:0] seed_cell(logic [1:0] k);
    logic [CAW-1:0] r;
    case (k)
      2'd0:    r = cell_addr(CW'(SEED_LO), CW'(SEED_HI));
      2'd1:    r = cell_addr(CW'(SEED_HI), CW'(SEED_LO));
      2'd2:    r = cell_addr(CW'(SEED_LO), CW'(SEED_LO));
      default: r = cell_addr(CW'(SEED_HI), CW'(SEED_HI));
    endcase
    return r;
  endfunction

endpackage

>>> rtl/mfs_ram.sv
`timescale 1ns / 1ps

module mfs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/mfs_cell_queue.sv
`timescale 1ns / 1ps

module mfs_cell_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mfs_pkg::q_ctrl_t        ctrl_i,
  input  logic [mfs_pkg::CAW-1:0] cell_i,
  output logic [mfs_pkg::CAW-1:0] cell_o,
  output mfs_pkg::q_stat_t        stat_o
);
  import mfs_pkg::*;

  logic [QAW-1:0] head_q, head_d;
  logic [QAW-1:0] tail_q, tail_d;
  logic [QCW-1:0] count_q, count_d;
  logic           do_push;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == QCW'(QUEUE_DEPTH));
  assign do_push      = ctrl_i.push && !stat_o.full;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (ctrl_i.flush) begin
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
    end else if (do_push) begin
      tail_d  = (tail_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + QAW'(1);
      count_d = count_q + QCW'(1);
    end else if (ctrl_i.pop && !stat_o.empty) begin
      head_d  = (head_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_q + QAW'(1);
      count_d = count_q - QCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  mfs_ram #(.Width(CAW), .Depth(QUEUE_DEPTH)) u_qram (
    .clk_i   (clk_i),
    .we_i    (do_push && !ctrl_i.flush),
    .waddr_i (tail_q),
    .wdata_i (cell_i),
    .raddr_i (head_q),
    .rdata_o (cell_o)
  );

endmodule

>>> rtl/maze_floodfill_step.sv
`timescale 1ns / 1ps
// flood-fill step for a maze-solving robot on a 16x16 grid
// input channel (in_valid_i/in_ready_o/in_data_i): one wall-sensor reading for
//   the current cell and a goal select (centre cells or start cell)
// output channel (out_valid_o/out_ready_i/out_data_o): one result per input with
//   the action code, the new position and heading, and the distance of the old cell
// each transaction runs through: wall marking, a distance/visited clear over all 256
//   cells, seeding (the start cell or the four centre cells), the breadth-first
//   flood (each reached cell is popped from the queue and its open neighbors
//   updated) and the move decision
// in an open maze the flood reaches all 256 cells; the flood loop, one neighbor at
//   a time over the distance memory, sets the length of a transaction
// in_ready_o is high only while the block is idle; one transaction at a time
// the result sits in an output register, so a stalled receiver does not stop the
//   next transaction from being accepted; the block only waits at the end of a
//   transaction if the previous result has still not been taken
// after reset the wall map is loaded with the outer boundary walls in a pass over
//   all 256 cells, with in_ready_o low; position is (0,0), heading north
module maze_floodfill_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mfs_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mfs_pkg::out_t out_data_o
);
  import mfs_pkg::*;

  `include "maze_floodfill_step_assert.svh"

  state_e              st_q, st_d;
  logic [CAW-1:0]      cnt_q, cnt_d;
  logic [1:0]          dir_q, dir_d;
  logic [WW-1:0]       m_q, m_d;
  logic [2:0]          sense_q, sense_d;   // {left, right, front}
  logic                home_q, home_d;
  logic [CAW-1:0]      tgt_q, tgt_d;
  logic [WW-1:0]       msk_q, msk_d;
  logic [CAW-1:0]      cell_q, cell_d;
  logic [DW-1:0]       cdist_q, cdist_d;
  logic [WW-1:0]       cwall_q, cwall_d;
  logic                oob_q, oob_d;
  logic [3:0][DW-1:0]  dd_q, dd_d;
  logic [CW-1:0]       pos_x_q, pos_x_d;
  logic [CW-1:0]       pos_y_q, pos_y_d;
  logic [1:0]          head_q, head_d;
  out_t                out_q, out_d;
  logic                out_vld_q, out_vld_d;

  logic                wall_we;
  logic [CAW-1:0]      wall_waddr, wall_raddr;
  logic [WW-1:0]       wall_wdata, wall_rdata;
  logic                dist_we;
  logic [CAW-1:0]      dist_waddr, dist_raddr;
  logic [DW-1:0]       dist_wdata, dist_rdata;
  logic                vis_we;
  logic [CAW-1:0]      vis_waddr, vis_raddr;
  logic                vis_wdata, vis_rdata;

  q_ctrl_t             qctl;
  q_stat_t             qstat;
  logic [CAW-1:0]      q_wcell, q_rcell;

  assign in_ready_o  = (st_q == ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_comb begin
    nb_t           nb;
    logic [1:0]    d;
    logic [8:0]    cand;
    logic          wf, wr, wl;
    logic [DW-1:0] cur;
    logic [2:0]    act;
    logic [1:0]    nh;

    st_d      = st_q;
    cnt_d     = cnt_q;
    dir_d     = dir_q;
    m_d       = m_q;
    sense_d   = sense_q;
    home_d    = home_q;
    tgt_d     = tgt_q;
    msk_d     = msk_q;
    cell_d    = cell_q;
    cdist_d   = cdist_q;
    cwall_d   = cwall_q;
    oob_d     = oob_q;
    dd_d      = dd_q;
    pos_x_d   = pos_x_q;
    pos_y_d   = pos_y_q;
    head_d    = head_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !out_ready_i;

    wall_we    = 1'b0;
    wall_waddr = tgt_q;
    wall_wdata = wall_rdata | msk_q;
    wall_raddr = cell_addr(pos_x_q, pos_y_q);
    dist_we    = 1'b0;
    dist_waddr = tgt_q;
    dist_wdata = FAR_DIST;
    dist_raddr = cell_addr(pos_x_q, pos_y_q);
    vis_we     = 1'b0;
    vis_waddr  = tgt_q;
    vis_wdata  = 1'b0;
    vis_raddr  = tgt_q;
    qctl       = '0;
    q_wcell    = tgt_q;

    nb   = neighbor(pos_x_q, pos_y_q, head_q);
    d    = head_q;
    cand = {1'b0, cdist_q} + 9'd1;
    wf   = sense_q[0];
    wr   = sense_q[1];
    wl   = sense_q[2];
    cur  = dd_q[0];
    act  = ACT_FWD;
    nh   = head_q;

    case (st_q)
      ST_WINIT: begin
        wall_we    = 1'b1;
        wall_waddr = cnt_q;
        wall_wdata = wall_reset(cnt_q);
        cnt_d      = cnt_q + CAW'(1);
        if (cnt_q == '1) st_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          wf      = (in_data_i.wall_sensors & 4'b0110) != 4'b0000;
          wr      = in_data_i.wall_sensors[0];
          wl      = in_data_i.wall_sensors[3];
          m_d     = (wf ? dir_bit(head_q) : '0) | (wr ? dir_bit(head_q + 2'd1) : '0)
                  | (wl ? dir_bit(head_q + 2'd3) : '0);
          sense_d = {wl, wr, wf};
          home_d  = in_data_i.return_home;
          cnt_d   = '0;
          st_d    = ST_MARK_RD;
        end
      end
      ST_MARK_RD: begin
        // step 0 marks the current cell, steps 1..4 the neighbor per direction
        if (cnt_q[2:0] == 3'd0) begin
          tgt_d      = cell_addr(pos_x_q, pos_y_q);
          msk_d      = m_q;
          wall_raddr = cell_addr(pos_x_q, pos_y_q);
          st_d       = ST_MARK_WR;
        end else begin
          d  = 2'(cnt_q[2:0] - 3'd1);
          nb = neighbor(pos_x_q, pos_y_q, d);
          if (m_q[d] && nb.ok) begin
            tgt_d      = cell_addr(nb.x, nb.y);
            msk_d      = dir_bit(d + 2'd2);
            wall_raddr = cell_addr(nb.x, nb.y);
            st_d       = ST_MARK_WR;
          end else if (cnt_q[2:0] == 3'd4) begin
            cnt_d = '0;
            st_d  = ST_CLEAR;
          end else begin
            cnt_d = cnt_q + CAW'(1);
          end
        end
      end
      ST_MARK_WR: begin
        wall_we = 1'b1;
        if (cnt_q[2:0] == 3'd4) begin
          cnt_d = '0;
          st_d  = ST_CLEAR;
        end else begin
          cnt_d = cnt_q + CAW'(1);
          st_d  = ST_MARK_RD;
        end
      end
      ST_CLEAR: begin
        dist_we    = 1'b1;
        dist_waddr = cnt_q;
        dist_wdata = FAR_DIST;
        vis_we     = 1'b1;
        vis_waddr  = cnt_q;
        vis_wdata  = 1'b0;
        qctl.flush = 1'b1;
        cnt_d      = cnt_q + CAW'(1);
        if (cnt_q == '1) begin
          cnt_d = '0;
          st_d  = ST_SEED;
        end
      end
      ST_SEED: begin
        q_wcell    = home_q ? cell_addr('0, '0) : seed_cell(cnt_q[1:0]);
        dist_we    = 1'b1;
        dist_waddr = q_wcell;
        dist_wdata = '0;
        vis_we     = 1'b1;
        vis_waddr  = q_wcell;
        vis_wdata  = 1'b1;
        qctl.push  = 1'b1;
        if (home_q || cnt_q[1:0] == 2'd3) begin
          cnt_d = '0;
          st_d  = ST_POP;
        end else begin
          cnt_d = cnt_q + CAW'(1);
        end
      end
      ST_POP: begin
        if (qstat.empty) begin
          cnt_d = '0;
          st_d  = ST_DEC_RD;
        end else begin
          qctl.pop = 1'b1;
          st_d     = ST_QDAT;
        end
      end
      ST_QDAT: begin
        cell_d     = q_rcell;
        dist_raddr = q_rcell;
        wall_raddr = q_rcell;
        st_d       = ST_CELL;
      end
      ST_CELL: begin
        cdist_d = dist_rdata;
        cwall_d = wall_rdata;
        dir_d   = DIR_N;
        st_d    = ST_NB_RD;
      end
      ST_NB_RD: begin
        nb = neighbor(cell_q[CAW-1:CW], cell_q[CW-1:0], dir_q);
        if (cwall_q[dir_q] || !nb.ok) begin
          dir_d = dir_q + 2'd1;
          if (dir_q == DIR_W) st_d = ST_POP;
        end else begin
          tgt_d      = cell_addr(nb.x, nb.y);
          dist_raddr = cell_addr(nb.x, nb.y);
          vis_raddr  = cell_addr(nb.x, nb.y);
          st_d       = ST_NB_UPD;
        end
      end
      ST_NB_UPD: begin
        if ({1'b0, dist_rdata} > cand) begin
          dist_we    = 1'b1;
          dist_wdata = cand[DW-1:0];
          if (!vis_rdata) begin
            vis_we    = 1'b1;
            vis_wdata = 1'b1;
            qctl.push = 1'b1;
          end
        end
        dir_d = dir_q + 2'd1;
        st_d  = (dir_q == DIR_W) ? ST_POP : ST_NB_RD;
      end
      ST_DEC_RD: begin
        // slot 0 current cell, then front, right, left
        case (cnt_q[1:0])
          2'd1:    d = head_q;
          2'd2:    d = head_q + 2'd1;
          default: d = head_q + 2'd3;
        endcase
        nb = neighbor(pos_x_q, pos_y_q, d);
        if (cnt_q[1:0] == 2'd0) begin
          dist_raddr = cell_addr(pos_x_q, pos_y_q);
          oob_d      = 1'b0;
        end else begin
          dist_raddr = cell_addr(nb.x, nb.y);
          oob_d      = !nb.ok;
        end
        st_d = ST_DEC_CAP;
      end
      ST_DEC_CAP: begin
        dd_d[cnt_q[1:0]] = oob_q ? FAR_DIST : dist_rdata;
        if (cnt_q[1:0] == 2'd3) begin
          st_d = ST_FINISH;
        end else begin
          cnt_d = cnt_q + CAW'(1);
          st_d  = ST_DEC_RD;
        end
      end
      ST_FINISH: begin
        if (dd_q[1] <= cur && !wf) begin
          act = ACT_FWD;
          nh  = head_q;
        end else if (dd_q[2] <= cur && !wr) begin
          act = wl ? ACT_RIGHT_CAL : ACT_RIGHT;
          nh  = head_q + 2'd1;
        end else if (dd_q[3] <= cur && !wl) begin
          act = wr ? ACT_LEFT_CAL : ACT_LEFT;
          nh  = head_q + 2'd3;
        end else begin
          act = ACT_UTURN;
          nh  = head_q + 2'd2;
        end
        nb = neighbor(pos_x_q, pos_y_q, nh);
        if (!out_vld_q || out_ready_i) begin
          head_d = nh;
          if (nb.ok) begin
            pos_x_d = nb.x;
            pos_y_d = nb.y;
          end
          out_d.action        = act;
          out_d.new_x         = 4'(nb.x);
          out_d.new_y         = 4'(nb.y);
          out_d.new_heading   = nh;
          out_d.cell_distance = cur;
          out_vld_d           = 1'b1;
          st_d                = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_WINIT;
      cnt_q     <= '0;
      dir_q     <= DIR_N;
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      head_q    <= DIR_N;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      cnt_q     <= cnt_d;
      dir_q     <= dir_d;
      pos_x_q   <= pos_x_d;
      pos_y_q   <= pos_y_d;
      head_q    <= head_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q     <= m_d;
    sense_q <= sense_d;
    home_q  <= home_d;
    tgt_q   <= tgt_d;
    msk_q   <= msk_d;
    cell_q  <= cell_d;
    cdist_q <= cdist_d;
    cwall_q <= cwall_d;
    oob_q   <= oob_d;
    dd_q    <= dd_d;
    out_q   <= out_d;
  end

  mfs_ram #(.Width(WW), .Depth(NMEM)) u_wall_ram (
    .clk_i   (clk_i),
    .we_i    (wall_we),
    .waddr_i (wall_waddr),
    .wdata_i (wall_wdata),
    .raddr_i (wall_raddr),
    .rdata_o (wall_rdata)
  );

  mfs_ram #(.Width(DW), .Depth(NMEM)) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (dist_waddr),
    .wdata_i (dist_wdata),
    .raddr_i (dist_raddr),
    .rdata_o (dist_rdata)
  );

  mfs_ram #(.Width(1), .Depth(NMEM)) u_vis_ram (
    .clk_i   (clk_i),
    .we_i    (vis_we),
    .waddr_i (vis_waddr),
    .wdata_i (vis_wdata),
    .raddr_i (vis_raddr),
    .rdata_o (vis_rdata)
  );

  mfs_cell_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (qctl),
    .cell_i (q_wcell),
    .cell_o (q_rcell),
    .stat_o (qstat)
  );

  `MFS_ASSERT_NEXT(a_accept_marks, clk_i, rst_ni, in_valid_i && in_ready_o, st_q == ST_MARK_RD)
  `MFS_ASSERT_NEXT(a_finish_outputs, clk_i, rst_ni, st_q == ST_FINISH && (!out_vld_q || out_ready_i), out_valid_o && st_q == ST_IDLE)
  `MFS_ASSERT_NOW(a_action_range, clk_i, rst_ni, out_valid_o, out_data_o.action <= 3'(ACT_UTURN))
  `MFS_ASSERT_NOW(a_pos_in_grid, clk_i, rst_ni, 1'b1, {1'b0, pos_x_q} < (CW+1)'(GRID_SIDE) && {1'b0, pos_y_q} < (CW+1)'(GRID_SIDE))

endmodule
